// ===== rtl/core/rtph_pkg.sv =====
// ----------------------------------------------------------------------------
// rtph_pkg
// Shared types and constants of the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
package rtph_pkg;

    // fixed RTP header length in bytes
    localparam int HEADER_BYTES = 12;

    // packet position counter saturates just past the FU-A header byte
    localparam int POS_BITS = $clog2(HEADER_BYTES + 3);
    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t POS_PAYLOAD   = pos_t'(HEADER_BYTES);
    localparam pos_t POS_FU_HEADER = pos_t'(HEADER_BYTES + 1);
    localparam pos_t POS_MAX       = pos_t'(HEADER_BYTES + 2);

    // nal unit type codes
    localparam logic [4:0] TYPE_NONE        = 5'd0;
    localparam logic [4:0] TYPE_SINGLE_LAST = 5'd23;
    localparam logic [4:0] TYPE_FU_A        = 5'd28;

    // start code is three zero bytes and a one, then the nal header byte
    localparam int START_CODE_BYTES = 4;
    localparam int PHASE_BITS = $clog2(START_CODE_BYTES + 1);
    typedef logic [PHASE_BITS-1:0] phase_t;

    localparam phase_t PHASE_CODE_ONE = phase_t'(START_CODE_BYTES - 1);
    localparam phase_t PHASE_HEADER   = phase_t'(START_CODE_BYTES);
    localparam logic [7:0] CODE_ONE   = 8'h01;

    // packet parsing mode
    typedef enum logic [3:0] {
        MODE_HEADER = 4'b0001,
        MODE_SINGLE = 4'b0010,
        MODE_FU_A   = 4'b0100,
        MODE_DROP   = 4'b1000
    } mode_t;

    // results caused by one packet byte
    typedef struct packed {
        logic       start_code;   // start code precedes the data byte
        logic       drop;         // single drop result
        logic       eop;          // last result of the packet
        logic [7:0] data;         // stream byte
    } burst_t;

    // emitter status toward the input side
    typedef struct packed {
        logic busy;               // a burst is held
        logic done;               // its last result leaves this cycle
    } emit_status_t;

endpackage

// ===== rtl/core/rtp_h264_depacketizer.sv =====
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// RTP to H.264 Annex-B converter for single NAL unit and FU-A packets.
// ----------------------------------------------------------------------------
// Packet bytes enter one per cycle while s_axis_tready is high, with tlast
// on the final byte; the 12-byte RTP header is stripped and Annex-B bytes
// leave on the master stream. A byte that opens a NAL unit gives five words
// (00 00 00 01 and the NAL header) and holds the single output burst
// register, so the next byte waits until the last of them is taken.
// Unsupported types and short packets give one word with tuser[1] set and
// tdata zero at the packet's last byte. tuser[0] marks the first start-code
// byte of each NAL unit; tlast marks the last word a packet causes. There is
// no configuration.
module rtp_h264_depacketizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // end_of_packet
    output logic [1:0]  m_axis_tuser    // unit_start, status
);

    rtph_pkg::burst_t       burst;
    rtph_pkg::emit_status_t emit_status;
    logic                   load;
    logic                   accept;

    // take a byte when the burst register is free or frees this cycle
    assign s_axis_tready = !emit_status.busy || emit_status.done;
    assign accept        = s_axis_tvalid && s_axis_tready;

    rtph_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .load      (load),
        .burst     (burst)
    );

    rtph_emitter u_emitter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .burst         (burst),
        .status        (emit_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // a start code begins with a zero byte and is never a drop word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00 && !m_axis_tuser[1])
        else $error("unit start word malformed");

    // a drop word is zero and ends its packet
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'h00 && m_axis_tlast)
        else $error("drop word malformed");

    // no byte is taken while the held burst is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken over a stalled burst");

    // a unit start word is followed by the rest of the start code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=>
            m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tlast)
        else $error("start code cut short");
`endif

endmodule

// ===== rtl/core/rtph_parser.sv =====
// ----------------------------------------------------------------------------
// rtph_parser
// Tracks the packet position and mode and turns each accepted byte into a
// burst of results.
// ----------------------------------------------------------------------------
module rtph_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                load,
    output rtph_pkg::burst_t    burst
);

    rtph_pkg::mode_t mode_reg, mode_next;
    rtph_pkg::pos_t  pos_reg, pos_next;
    logic [2:0]      ind_reg, ind_next;
    logic [4:0]      nal_type;

    assign nal_type = data_byte[4:0];

    // decode one byte
    always_comb
    begin
        burst            = '0;
        burst.eop        = last_byte;
        burst.data       = data_byte;
        load             = 1'b0;
        mode_next        = mode_reg;
        ind_next         = ind_reg;
        unique case (mode_reg)
            rtph_pkg::MODE_HEADER:
            begin
                if (pos_reg < rtph_pkg::POS_PAYLOAD)
                begin
                    burst.drop = 1'b1;
                    load       = last_byte;
                end
                else if (nal_type != rtph_pkg::TYPE_NONE &&
                         nal_type <= rtph_pkg::TYPE_SINGLE_LAST)
                begin
                    burst.start_code = 1'b1;
                    load             = 1'b1;
                    mode_next        = rtph_pkg::MODE_SINGLE;
                end
                else if (nal_type == rtph_pkg::TYPE_FU_A)
                begin
                    burst.drop = 1'b1;
                    load       = last_byte;
                    ind_next   = data_byte[7:5];
                    mode_next  = rtph_pkg::MODE_FU_A;
                end
                else
                begin
                    burst.drop = 1'b1;
                    load       = last_byte;
                    mode_next  = rtph_pkg::MODE_DROP;
                end
            end
            rtph_pkg::MODE_SINGLE:
            begin
                load = 1'b1;
            end
            rtph_pkg::MODE_FU_A:
            begin
                if (pos_reg == rtph_pkg::POS_FU_HEADER)
                begin
                    // rebuilt nal header on the start fragment only
                    burst.start_code = 1'b1;
                    burst.data       = {ind_reg, data_byte[4:0]};
                    load             = data_byte[7];
                end
                else
                begin
                    load = 1'b1;
                end
            end
            rtph_pkg::MODE_DROP:
            begin
                burst.drop = 1'b1;
                load       = last_byte;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        load = load & accept;
        if (last_byte)
        begin
            mode_next = rtph_pkg::MODE_HEADER;
        end
    end

    // saturating byte position
    always_comb
    begin
        if (last_byte)
        begin
            pos_next = '0;
        end
        else if (pos_reg < rtph_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rtph_pkg::MODE_HEADER;
            pos_reg  <= '0;
            ind_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ind_reg  <= ind_next;
        end
    end

endmodule

// ===== rtl/core/rtph_emitter.sv =====
// ----------------------------------------------------------------------------
// rtph_emitter
// Holds one burst and plays it out a word at a time on the output stream.
// ----------------------------------------------------------------------------
module rtph_emitter
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  rtph_pkg::burst_t        burst,
    output rtph_pkg::emit_status_t  status,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // out_byte
    output logic                    m_axis_tlast,   // end_of_packet
    output logic [1:0]              m_axis_tuser    // unit_start, status
);

    rtph_pkg::burst_t burst_reg;
    rtph_pkg::phase_t phase_reg, phase_next;
    logic             valid_reg, valid_next;
    logic             last_phase;
    logic             fire;

    assign last_phase = !burst_reg.start_code || (phase_reg == rtph_pkg::PHASE_HEADER);
    assign fire       = valid_reg && m_axis_tready;

    assign status.busy = valid_reg;
    assign status.done = fire && last_phase;

    // output word from the held burst
    always_comb
    begin
        if (burst_reg.start_code && phase_reg < rtph_pkg::PHASE_CODE_ONE)
        begin
            m_axis_tdata = 8'h00;
        end
        else if (burst_reg.start_code && phase_reg == rtph_pkg::PHASE_CODE_ONE)
        begin
            m_axis_tdata = rtph_pkg::CODE_ONE;
        end
        else if (burst_reg.drop)
        begin
            m_axis_tdata = 8'h00;
        end
        else
        begin
            m_axis_tdata = burst_reg.data;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tlast    = burst_reg.eop && last_phase;
    assign m_axis_tuser[0] = burst_reg.start_code && (phase_reg == '0);
    assign m_axis_tuser[1] = burst_reg.drop;

    // phase and valid sequencing
    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = '0;
        end
        else if (status.done)
        begin
            valid_next = 1'b0;
            phase_next = '0;
        end
        else if (fire)
        begin
            phase_next = phase_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

endmodule
